>>> sv/cll_pkg.sv
package cll_pkg;

   localparam logic [1:0] OP_INSERT   = 2'd0;
   localparam logic [1:0] OP_DELETE   = 2'd1;
   localparam logic [1:0] OP_TRAVERSE = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]         op;
      logic [5:0]         position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               has_value;
      logic signed [31:0] element;
      logic [5:0]         count;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic link_we;
      logic value_we;
   } store_ctl_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_INS_FREE,
      ST_INS_TAKE,
      ST_WALK,
      ST_INS_LINK,
      ST_DEL_NEXT,
      ST_DEL_FREE,
      ST_DEL_PUSH,
      ST_TRAV_HEAD,
      ST_TRAV_RD,
      ST_TRAV,
      ST_EMIT
   } seq_state_type;

endpackage

>>> sv/cll_store.sv
module cll_store
   import cll_pkg::*;
#(
   parameter int ENTRIES     = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                       clock,
   input  store_ctl_type              ctl,
   input  logic [$clog2(ENTRIES)-1:0] link_waddr,
   input  logic [$clog2(ENTRIES)-1:0] link_wdata,
   input  logic [$clog2(ENTRIES)-1:0] value_waddr,
   input  logic [VALUE_WIDTH-1:0]     value_wdata,
   input  logic [$clog2(ENTRIES)-1:0] raddr,
   output logic [$clog2(ENTRIES)-1:0] link_rdata,
   output logic [VALUE_WIDTH-1:0]     value_rdata
);

   localparam int AW = $clog2(ENTRIES);

   logic [AW-1:0]          link_mem [ENTRIES];
   logic [VALUE_WIDTH-1:0] value_mem [ENTRIES];
   logic [AW-1:0]          link_rdata_ff;
   logic [VALUE_WIDTH-1:0] value_rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rdata_ff <= link_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (ctl.value_we) begin
         value_mem[value_waddr] <= value_wdata;
      end
      value_rdata_ff <= value_mem[raddr];
   end

   assign link_rdata  = link_rdata_ff;
   assign value_rdata = value_rdata_ff;

endmodule

>>> sv/cll_seq.sv
module cll_seq
   import cll_pkg::*;
#(
   parameter int ENTRIES     = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  req_type                    req_data,
   output logic                       busy,
   input  logic                       slot_free,
   output logic                       res_load,
   output rsp_type                    res_data,
   output store_ctl_type              ctl,
   output logic [$clog2(ENTRIES)-1:0] link_waddr,
   output logic [$clog2(ENTRIES)-1:0] link_wdata,
   output logic [$clog2(ENTRIES)-1:0] value_waddr,
   output logic [VALUE_WIDTH-1:0]     value_wdata,
   output logic [$clog2(ENTRIES)-1:0] raddr,
   input  logic [$clog2(ENTRIES)-1:0] link_rdata,
   input  logic [VALUE_WIDTH-1:0]     value_rdata
);

   localparam int AW   = $clog2(ENTRIES);
   localparam int CMPW = ((AW > 6) ? AW : 6) + 1;
   localparam logic [AW-1:0] HDR      = AW'(ENTRIES - 1);
   localparam logic [AW-1:0] LAST_BUF = AW'(ENTRIES - 2);

   seq_state_type          state_ff, state_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic [1:0]             op_ff, op_in;
   logic [5:0]             pos_ff, pos_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [AW-1:0]          j_ff, j_in;
   logic [AW-1:0]          k_ff, k_in;
   logic [5:0]             steps_ff, steps_in;
   logic [AW-1:0]          cnt_ff, cnt_in;
   logic [AW-1:0]          n_ff, n_in;
   logic [1:0]             status_ff, status_in;
   logic                   has_ff, has_in;
   logic [31:0]            elem_ff, elem_in;
   logic                   more_ff, more_in;

   logic [CMPW-1:0] pos_ext, cnt_ext, n_ext;
   logic            pos_ok_ins, pos_ok_del, link_bad, trav_fin, list_empty;
   logic [63:0]     req_val64, rd_val64;

   assign pos_ext    = CMPW'(pos_ff);
   assign cnt_ext    = CMPW'(cnt_ff);
   assign n_ext      = CMPW'(n_ff);
   assign pos_ok_ins = (pos_ff != 6'd0) && (pos_ext <= cnt_ext + CMPW'(1));
   assign pos_ok_del = (pos_ff != 6'd0) && (pos_ext <= cnt_ext);
   // free chain exhausted, or walked off the list
   assign link_bad   = (link_rdata == '0) || (link_rdata == HDR);
   assign trav_fin   = (link_rdata == '0) || (n_ext + CMPW'(1) >= cnt_ext);
   assign list_empty = (cnt_ff == '0) || (link_rdata == '0);
   assign req_val64  = 64'(req_data.value);
   assign rd_val64   = 64'(value_rdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         cnt_ff   <= '0;
         more_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         cnt_ff   <= cnt_in;
         more_ff  <= more_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      steps_ff  <= steps_in;
      n_ff      <= n_in;
      status_ff <= status_in;
      has_ff    <= has_in;
      elem_ff   <= elem_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == HDR) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (op_ff)
               OP_INSERT:   state_in = pos_ok_ins ? ST_INS_FREE : ST_EMIT;
               OP_DELETE:   state_in = pos_ok_del ? ST_WALK : ST_EMIT;
               OP_TRAVERSE: state_in = ST_TRAV_HEAD;
               default:     state_in = ST_EMIT;
            endcase
         end
         ST_INS_FREE:  state_in = link_bad ? ST_EMIT : ST_INS_TAKE;
         ST_INS_TAKE:  state_in = ST_WALK;
         ST_WALK: begin
            if (steps_ff != 6'd0) begin
               state_in = ST_WALK;
            end else if (op_ff == OP_INSERT) begin
               state_in = ST_INS_LINK;
            end else begin
               state_in = link_bad ? ST_EMIT : ST_DEL_NEXT;
            end
         end
         ST_INS_LINK:  state_in = ST_EMIT;
         ST_DEL_NEXT:  state_in = ST_DEL_FREE;
         ST_DEL_FREE:  state_in = ST_DEL_PUSH;
         ST_DEL_PUSH:  state_in = ST_EMIT;
         ST_TRAV_HEAD: state_in = list_empty ? ST_EMIT : ST_TRAV;
         ST_TRAV_RD:   state_in = ST_TRAV;
         ST_TRAV:      state_in = ST_EMIT;
         ST_EMIT: begin
            if (slot_free) state_in = more_ff ? ST_TRAV_RD : ST_IDLE;
         end
         default:      state_in = ST_CLEAR;
      endcase
   end

   // outputs and datapath
   always_comb begin
      clr_in      = clr_ff;
      op_in       = op_ff;
      pos_in      = pos_ff;
      val_in      = val_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      steps_in    = steps_ff;
      cnt_in      = cnt_ff;
      n_in        = n_ff;
      status_in   = status_ff;
      has_in      = has_ff;
      elem_in     = elem_ff;
      more_in     = more_ff;
      busy        = 1'b1;
      res_load    = 1'b0;
      ctl         = '0;
      link_waddr  = '0;
      link_wdata  = '0;
      value_waddr = j_ff;
      value_wdata = val_ff;
      raddr       = '0;
      case (state_ff)
         ST_CLEAR: begin
            ctl.link_we = 1'b1;
            link_waddr  = clr_ff;
            link_wdata  = (clr_ff < LAST_BUF) ? clr_ff + AW'(1) : '0;
            clr_in      = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (req_valid) begin
               op_in  = req_data.op;
               pos_in = req_data.position;
               val_in = req_val64[VALUE_WIDTH-1:0];
            end
         end
         ST_DECODE: begin
            status_in = STATUS_OK;
            has_in    = 1'b0;
            elem_in   = '0;
            more_in   = 1'b0;
            case (op_ff)
               OP_INSERT: begin
                  if (!pos_ok_ins) status_in = STATUS_RANGE;
                  raddr = '0;
               end
               OP_DELETE: begin
                  if (!pos_ok_del) status_in = STATUS_RANGE;
                  k_in     = HDR;
                  steps_in = pos_ff - 6'd1;
                  raddr    = HDR;
               end
               OP_TRAVERSE: begin
                  raddr = HDR;
               end
               default: begin
                  raddr = '0;
               end
            endcase
         end
         ST_INS_FREE: begin
            if (link_bad) begin
               status_in = STATUS_FULL;
            end else begin
               j_in  = link_rdata;
               raddr = link_rdata;
            end
         end
         ST_INS_TAKE: begin
            // unhook the taken entry from the free chain
            ctl.link_we  = 1'b1;
            ctl.value_we = 1'b1;
            link_waddr   = '0;
            link_wdata   = link_rdata;
            k_in         = HDR;
            steps_in     = pos_ff - 6'd1;
            raddr        = HDR;
         end
         ST_WALK: begin
            // link_rdata holds the link of entry k here
            if (steps_ff != 6'd0) begin
               k_in     = link_rdata;
               steps_in = steps_ff - 6'd1;
               raddr    = link_rdata;
            end else if (op_ff == OP_INSERT) begin
               ctl.link_we = 1'b1;
               link_waddr  = j_ff;
               link_wdata  = link_rdata;
            end else if (link_bad) begin
               status_in = STATUS_RANGE;
            end else begin
               j_in  = link_rdata;
               raddr = link_rdata;
            end
         end
         ST_INS_LINK: begin
            ctl.link_we = 1'b1;
            link_waddr  = k_ff;
            link_wdata  = j_ff;
            cnt_in      = cnt_ff + AW'(1);
         end
         ST_DEL_NEXT: begin
            ctl.link_we = 1'b1;
            link_waddr  = k_ff;
            link_wdata  = link_rdata;
            raddr       = '0;
         end
         ST_DEL_FREE: begin
            ctl.link_we = 1'b1;
            link_waddr  = j_ff;
            link_wdata  = link_rdata;
         end
         ST_DEL_PUSH: begin
            ctl.link_we = 1'b1;
            link_waddr  = '0;
            link_wdata  = j_ff;
            cnt_in      = cnt_ff - AW'(1);
         end
         ST_TRAV_HEAD: begin
            if (!list_empty) begin
               j_in  = link_rdata;
               n_in  = '0;
               raddr = link_rdata;
            end
         end
         ST_TRAV_RD: begin
            raddr = j_ff;
         end
         ST_TRAV: begin
            status_in = STATUS_OK;
            has_in    = 1'b1;
            elem_in   = rd_val64[31:0];
            more_in   = !trav_fin;
            j_in      = link_rdata;
            n_in      = n_ff + AW'(1);
         end
         ST_EMIT: begin
            res_load = slot_free;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   assign res_data.status    = status_ff;
   assign res_data.has_value = has_ff;
   assign res_data.element   = elem_ff;
   assign res_data.count     = 6'(cnt_ff);
   assign res_data.last      = !more_ff;

endmodule

>>> sv/cursor_linked_list_engine_core.sv
// list engine on a linked table of ENTRIES entries, value and link per entry
// req channel: one item carries op (insert, delete, traverse), a 1-based
// position and a value. req_stall is high whenever an item is in progress,
// so the block holds one item at a time
// rsp channel: insert, delete and an unused op give one item; traverse gives
// one item per list element in order (one item if the list is empty), last
// marks the final item of each request
// timing: insert and delete walk the links to the position, one table read
// per cycle; a bad position answers without a walk, and traverse reads each
// element in turn. the next req item is taken only once the rsp item is
// loaded. all cost comes from the single read port of the link table
// reset: a clearing pass rebuilds the free chain over all ENTRIES entries,
// one entry a cycle, with req_stall high throughout. the list starts empty
// a stalled rsp item is held in the output register; the next request is
// still taken, and the sequencer waits before overwriting a pending item
module cursor_linked_list_engine_core
   import cll_pkg::*;
#(
   parameter int ENTRIES     = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(ENTRIES);

   store_ctl_type          ctl;
   logic [AW-1:0]          link_waddr, link_wdata, value_waddr, raddr, link_rdata;
   logic [VALUE_WIDTH-1:0] value_wdata, value_rdata;
   logic                   busy, slot_free, res_load;
   rsp_type                res_data;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   cll_store #(
      .ENTRIES     (ENTRIES),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_store (
      .clock       (clock),
      .ctl         (ctl),
      .link_waddr  (link_waddr),
      .link_wdata  (link_wdata),
      .value_waddr (value_waddr),
      .value_wdata (value_wdata),
      .raddr       (raddr),
      .link_rdata  (link_rdata),
      .value_rdata (value_rdata)
   );

   cll_seq #(
      .ENTRIES     (ENTRIES),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .busy        (busy),
      .slot_free   (slot_free),
      .res_load    (res_load),
      .res_data    (res_data),
      .ctl         (ctl),
      .link_waddr  (link_waddr),
      .link_wdata  (link_wdata),
      .value_waddr (value_waddr),
      .value_wdata (value_wdata),
      .raddr       (raddr),
      .link_rdata  (link_rdata),
      .value_rdata (value_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sim/tb_cursor_linked_list_engine_core.sv
module tb_cursor_linked_list_engine_core;
   import cll_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   localparam int unsigned CAPACITY     = 62;
   localparam int unsigned RANDOM_ITEMS = 400;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 200;
   localparam longint unsigned LIMIT_NS = 64'd12_800_000;

   // one directed item; typed rows carry their single expected result in the row
   typedef struct packed {
      logic [1:0]  op;
      logic [5:0]  position;
      logic [31:0] value;
      bit          typed;
      logic [1:0]  status;
      logic [5:0]  count;
   } step_row_type;

   localparam step_row_type DIRECTED_STEPS [23] = '{
      '{OP_TRAVERSE, 6'd0,  32'h0000_0000, 1'b1, STATUS_OK,    6'd0},
      '{OP_DELETE,   6'd1,  32'h0000_0000, 1'b1, STATUS_RANGE, 6'd0},
      '{OP_INSERT,   6'd0,  32'h0000_0005, 1'b1, STATUS_RANGE, 6'd0},
      '{OP_INSERT,   6'd2,  32'h0000_0005, 1'b1, STATUS_RANGE, 6'd0},
      '{OP_INSERT,   6'd63, 32'h0000_0005, 1'b1, STATUS_RANGE, 6'd0},
      '{OP_UNUSED,   6'd0,  32'h0000_0000, 1'b1, STATUS_OK,    6'd0},
      '{OP_INSERT,   6'd1,  32'h7FFF_FFFF, 1'b1, STATUS_OK,    6'd1},
      '{OP_INSERT,   6'd1,  32'h8000_0000, 1'b1, STATUS_OK,    6'd2},
      '{OP_INSERT,   6'd3,  32'h0000_0000, 1'b1, STATUS_OK,    6'd3},
      '{OP_INSERT,   6'd2,  32'hFFFF_FFFF, 1'b1, STATUS_OK,    6'd4},
      '{OP_TRAVERSE, 6'd0,  32'h0000_0000, 1'b0, STATUS_OK,    6'd0},
      '{OP_DELETE,   6'd0,  32'h0000_0000, 1'b1, STATUS_RANGE, 6'd4},
      '{OP_DELETE,   6'd5,  32'h0000_0000, 1'b1, STATUS_RANGE, 6'd4},
      '{OP_DELETE,   6'd63, 32'h0000_0000, 1'b1, STATUS_RANGE, 6'd4},
      '{OP_DELETE,   6'd4,  32'h0000_0000, 1'b1, STATUS_OK,    6'd3},
      '{OP_DELETE,   6'd1,  32'h0000_0000, 1'b1, STATUS_OK,    6'd2},
      '{OP_UNUSED,   6'd63, 32'hFFFF_FFFF, 1'b1, STATUS_OK,    6'd2},
      '{OP_INSERT,   6'd3,  32'h5555_5555, 1'b1, STATUS_OK,    6'd3},
      '{OP_INSERT,   6'd2,  32'hAAAA_AAAA, 1'b1, STATUS_OK,    6'd4},
      '{OP_INSERT,   6'd6,  32'h0000_0000, 1'b1, STATUS_RANGE, 6'd4},
      '{OP_TRAVERSE, 6'd63, 32'hFFFF_FFFF, 1'b0, STATUS_OK,    6'd0},
      '{OP_DELETE,   6'd2,  32'h0000_0000, 1'b1, STATUS_OK,    6'd3},
      '{OP_TRAVERSE, 6'd0,  32'h0000_0000, 1'b0, STATUS_OK,    6'd0}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic signed [31:0] list_values[$];
   rsp_type            op_outcome[$];
   rsp_type            expected_rsp[$];
   int unsigned        mismatch_count = 0;
   int unsigned        rsp_seen = 0;
   bit                 quiet = 1'b0;
   bit                 long_hold_request = 1'b0;

   cursor_linked_list_engine_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic note_outcome(input logic [1:0] status, input logic has_value,
                               input logic signed [31:0] element, input logic last);
      op_outcome.push_back('{status: status, has_value: has_value, element: element,
                             count: 6'(list_values.size()), last: last});
   endtask

   // applies one item to the list image and leaves its results in op_outcome
   task automatic list_apply(input req_type item);
      int unsigned n;
      n = list_values.size();
      op_outcome.delete();
      case (item.op)
         OP_INSERT: begin
            if (item.position == 0 || item.position > n + 1)
               note_outcome(STATUS_RANGE, 1'b0, '0, 1'b1);
            else if (n == CAPACITY)
               note_outcome(STATUS_FULL, 1'b0, '0, 1'b1);
            else begin
               list_values.insert(item.position - 1, item.value);
               note_outcome(STATUS_OK, 1'b0, '0, 1'b1);
            end
         end
         OP_DELETE: begin
            if (item.position == 0 || item.position > n)
               note_outcome(STATUS_RANGE, 1'b0, '0, 1'b1);
            else begin
               list_values.delete(item.position - 1);
               note_outcome(STATUS_OK, 1'b0, '0, 1'b1);
            end
         end
         OP_TRAVERSE: begin
            if (n == 0)
               note_outcome(STATUS_OK, 1'b0, '0, 1'b1);
            for (int i = 0; i < n; i++)
               note_outcome(STATUS_OK, 1'b1, list_values[i], i == n - 1);
         end
         default: note_outcome(STATUS_OK, 1'b0, '0, 1'b1);
      endcase
   endtask

   task automatic send_item(input req_type item, input bit typed, input rsp_type typed_rsp);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      list_apply(item);
      if (typed)
         expected_rsp.push_back(typed_rsp);
      else
         foreach (op_outcome[i]) expected_rsp.push_back(op_outcome[i]);
   endtask

   task automatic sender_gap(input bit busy);
      if (!quiet && busy && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   function automatic req_type random_item(input int unsigned insert_share);
      req_type     item;
      int unsigned n, pick, top;
      n = list_values.size();
      pick = $urandom_range(0, 99);
      if (pick < 4)
         item.op = OP_UNUSED;
      else if (pick < 14)
         item.op = OP_TRAVERSE;
      else if (pick < 14 + insert_share)
         item.op = OP_INSERT;
      else
         item.op = OP_DELETE;
      if ($urandom_range(0, 9) == 0)
         case ($urandom_range(0, 3))
            0: item.value = 32'h7FFF_FFFF;
            1: item.value = 32'h8000_0000;
            2: item.value = 32'h0000_0000;
            default: item.value = 32'hFFFF_FFFF;
         endcase
      else
         item.value = $urandom;
      // mostly positions inside the list, the rest out of range on either side
      top = (item.op == OP_INSERT) ? n + 1 : n;
      if (top >= 1 && $urandom_range(0, 99) < 85)
         item.position = 6'($urandom_range(1, top));
      else if (top < 63 && $urandom_range(0, 1) == 1)
         item.position = 6'($urandom_range(top + 1, 63));
      else
         item.position = 6'd0;
      return item;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t rsp item %0d: %s got %h want %h", $time, rsp_seen, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0)
            report_mismatch("unexpected item, element", rsp_data.element, '0);
         else begin
            want = expected_rsp.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.has_value !== want.has_value)
               report_mismatch("has_value", rsp_data.has_value, want.has_value);
            if (rsp_data.element !== want.element)
               report_mismatch("element", rsp_data.element, want.element);
            if (rsp_data.count !== want.count)
               report_mismatch("count", rsp_data.count, want.count);
            if (rsp_data.last !== want.last)
               report_mismatch("last", rsp_data.last, want.last);
         end
         rsp_seen++;
      end
   end

   // receiver: short stall bursts in busy stretches, one long hold-off on request
   initial begin : rsp_side
      bit busy;
      busy = 1'b1;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 99) == 0) busy = !busy;
         if (long_hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold_request = 1'b0;
         end else if (!quiet && busy && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      step_row_type row;
      rsp_type      typed_rsp;
      int unsigned  insert_share;
      bit           tx_busy;
      tx_busy = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < $size(DIRECTED_STEPS); k++) begin
         row = DIRECTED_STEPS[k];
         typed_rsp = '{status: row.status, has_value: 1'b0, element: '0,
                       count: row.count, last: 1'b1};
         send_item('{op: row.op, position: row.position, value: row.value},
                   row.typed, typed_rsp);
         sender_gap(tx_busy);
      end

      // fill past full, drain to empty, then a balanced mix
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == 60) long_hold_request = 1'b1;
         if (k == 340) quiet = 1'b1;
         if ($urandom_range(0, 29) == 0) tx_busy = !tx_busy;
         insert_share = (k < 130) ? 78 : (k < 250) ? 10 : 43;
         send_item(random_item(insert_share), 1'b0, '0);
         sender_gap(tx_busy);
      end
      req_valid <= 1'b0;

      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin : watchdog
      #LIMIT_NS;
      $display("Test completed with failures");
      $finish;
   end

endmodule
